// ----- design/teq_pkg.sv -----
// shared types, codes and constants of the timer event queue
`default_nettype none

package teq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // time constants
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [19:0] USEC_MAX     = 20'd999999;
  localparam logic [9:0]  USEC_PER_MS  = 10'd1000;

  // divide by one million: drop 6 bits, then multiply by ceil(2^40 / 15625)
  localparam int unsigned PRE_SHIFT   = 6;
  localparam int unsigned RECIP_SHIFT = 40;
  localparam logic [26:0] RECIP_M     = 27'd70368745;
  localparam int unsigned QUO_W       = 13;

  // cycles of deadline arithmetic before the queue update
  localparam logic [1:0] DL_LAT = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] event_handle;
    logic [31:0] event_payload;
    logic [21:0] delay_ms;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_handle;
    logic [31:0] out_payload;
    logic [31:0] wait_sec;
    logic [19:0] wait_usec;
    logic        head_due;
  } out_word_t;

  // one queue slot
  typedef struct packed {
    logic        vld;
    logic [31:0] sec;
    logic [19:0] usec;
    logic [31:0] handle;
    logic [31:0] payload;
  } teq_ent_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic       upd;
    logic [1:0] cmd;
    teq_ent_t   ins;
  } teq_ctl_t;

  function automatic logic [19:0] clamp_usec(input logic [19:0] u);
    clamp_usec = (u > USEC_MAX) ? USEC_MAX : u;
  endfunction

endpackage

`default_nettype wire

// ----- design/teq_deadline.sv -----
// deadline arithmetic: now plus a delay in ms, microseconds normalized, seconds saturated
`default_nettype none

module teq_deadline (
  input  wire logic        clk,
  input  wire logic [21:0] delay_ms,
  input  wire logic [31:0] now_sec,
  input  wire logic [19:0] now_usec,
  output logic      [31:0] dl_sec,
  output logic      [19:0] dl_usec
);

  // stage 1: total microseconds
  logic [31:0] tu1_r, tu1_nxt;
  logic [31:0] ns1_r;
  // stage 2: whole seconds in the microsecond total
  logic [teq_pkg::QUO_W-1:0] q2_r, q2_nxt;
  logic [31:0] tu2_r;
  logic [31:0] ns2_r;
  logic [52:0] recip_prod;
  // stage 3: normalized, saturated deadline
  logic [31:0] dls_r, dls_nxt;
  logic [19:0] dlu_r, dlu_nxt;
  logic [31:0] qm;
  logic [31:0] rem;
  logic [32:0] ts;

  always_comb begin
    tu1_nxt = 32'(delay_ms) * 32'(teq_pkg::USEC_PER_MS) + 32'(now_usec);
  end

  always_comb begin
    recip_prod = 53'(tu1_r[31:teq_pkg::PRE_SHIFT]) * 53'(teq_pkg::RECIP_M);
    q2_nxt     = recip_prod[teq_pkg::RECIP_SHIFT +: teq_pkg::QUO_W];
  end

  always_comb begin
    qm  = 32'(q2_r) * 32'(teq_pkg::USEC_PER_SEC);
    rem = tu2_r - qm;
    ts  = {1'b0, ns2_r} + 33'(q2_r);
    if (ts[32]) begin
      dls_nxt = '1;
      dlu_nxt = teq_pkg::USEC_MAX;
    end else begin
      dls_nxt = ts[31:0];
      dlu_nxt = rem[19:0];
    end
  end

  always_ff @(posedge clk) begin
    tu1_r <= tu1_nxt;
    ns1_r <= now_sec;
    q2_r  <= q2_nxt;
    tu2_r <= tu1_r;
    ns2_r <= ns1_r;
    dls_r <= dls_nxt;
    dlu_r <= dlu_nxt;
  end

  assign dl_sec  = dls_r;
  assign dl_usec = dlu_r;

endmodule

`default_nettype wire

// ----- design/teq_cell.sv -----
// one slot of the sorted queue, shifting toward or away from the head
`default_nettype none

module teq_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire teq_pkg::teq_ctl_t ctl,
  input  wire teq_pkg::teq_ent_t prev_ent,
  input  wire teq_pkg::teq_ent_t next_ent,
  input  wire logic              prev_gt,
  input  wire logic              hit_in,
  output logic                   gt_out,
  output logic                   hit_out,
  output teq_pkg::teq_ent_t      ent
);

  teq_pkg::teq_ent_t ent_r, ent_nxt;

  // new deadline strictly later than ours: new word goes somewhere behind us
  assign gt_out  = ent_r.vld &&
                   ({ctl.ins.sec, ctl.ins.usec} > {ent_r.sec, ent_r.usec});
  // first handle match from the head
  assign hit_out = hit_in || (ent_r.vld && (ent_r.handle == ctl.ins.handle));

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.upd) begin
      case (ctl.cmd)
        teq_pkg::CMD_ADD: begin
          if (!gt_out) begin
            ent_nxt = prev_gt ? ctl.ins : prev_ent;
          end
        end
        teq_pkg::CMD_POP: begin
          ent_nxt = next_ent;
        end
        teq_pkg::CMD_REMOVE: begin
          if (hit_out) begin
            ent_nxt = next_ent;
          end
        end
        default: begin
          ent_nxt = ent_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

// ----- design/timer_event_queue.sv -----
// top level: sorted timer event queue built as a chain of slot cells
//
//   channel  dir  ports                          word / data
//   in       in   in_valid, in_stall (out)       in_word  (teq_pkg::in_word_t)
//   out      out  out_valid, out_stall (in)      out_word (teq_pkg::out_word_t)
//   cfg      in   cfg_wr_en                      cfg_wr_data (idle_wait_sec)
//
// every command first runs through the registered deadline arithmetic
// (ms-to-us multiply, reciprocal multiply for the divide by one million,
// remainder and saturation), then an update in which all cells shift at once
// the next word is accepted in the cycle the current one updates the queue
// a stalled result holds the update of the following word, and with it the intake
// reset empties every slot and sets idle_wait_sec to all ones
`default_nettype none

module timer_event_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire teq_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output teq_pkg::out_word_t      out_word,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data
);

  localparam int unsigned D = teq_pkg::QUEUE_DEPTH;

  // control
  logic       busy_r, busy_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;
  logic       exec;

  // held command and result
  teq_pkg::in_word_t  in_r;
  teq_pkg::out_word_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        idle_wait_r;

  // deadline
  logic [19:0] nusec;
  logic [31:0] dl_sec;
  logic [19:0] dl_usec;

  // cell chain
  teq_pkg::teq_ctl_t ctl;
  teq_pkg::teq_ent_t ent [D];
  logic [D:0]        gt_chain;
  logic [D:0]        hit_chain;
  logic [D-1:0]      vld_vec;
  logic              full;
  logic              empty;
  logic              found;

  // query arithmetic
  logic        later;
  logic        borrow;
  logic [20:0] hu_ext;

  assign nusec = teq_pkg::clamp_usec(in_r.now_usec);

  // update fires once the deadline is settled and the result slot is free
  assign exec     = busy_r && (cnt_r == teq_pkg::DL_LAT) && (!out_valid_r || !out_stall);
  assign in_stall = busy_r && !exec;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (busy_r && (cnt_r != teq_pkg::DL_LAT)) begin
      cnt_nxt = cnt_r + 2'd1;
    end
    if (exec) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
      idle_wait_r <= '1;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        idle_wait_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_word;
    end
    if (exec) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  teq_deadline u_deadline (
    .clk      (clk),
    .delay_ms (in_r.delay_ms),
    .now_sec  (in_r.now_sec),
    .now_usec (nusec),
    .dl_sec   (dl_sec),
    .dl_usec  (dl_usec)
  );

  // broadcast to the cells; a full queue leaves an add without effect
  always_comb begin
    ctl.cmd         = in_r.cmd;
    ctl.upd         = exec && (in_r.cmd != teq_pkg::CMD_QUERY) &&
                      !((in_r.cmd == teq_pkg::CMD_ADD) && full);
    ctl.ins.vld     = 1'b1;
    ctl.ins.sec     = dl_sec;
    ctl.ins.usec    = dl_usec;
    ctl.ins.handle  = in_r.event_handle;
    ctl.ins.payload = in_r.event_payload;
  end

  // head cell sees a virtual earlier neighbor, so the insert point can be slot 0
  assign gt_chain[0]  = 1'b1;
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    teq_pkg::teq_ent_t prev_e;
    teq_pkg::teq_ent_t next_e;
    if (i == 0) begin : g_head
      assign prev_e = '0;
    end else begin : g_mid
      assign prev_e = ent[i-1];
    end
    if (i == D - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = ent[i+1];
    end
    teq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .prev_ent (prev_e),
      .next_ent (next_e),
      .prev_gt  (gt_chain[i]),
      .hit_in   (hit_chain[i]),
      .gt_out   (gt_chain[i+1]),
      .hit_out  (hit_chain[i+1]),
      .ent      (ent[i])
    );
    assign vld_vec[i] = ent[i].vld;
  end

  // occupied slots always form a run from the head
  assign full  = vld_vec[D-1];
  assign empty = !vld_vec[0];
  assign found = hit_chain[D];

  // time left until the head deadline
  always_comb begin
    later  = {ent[0].sec, ent[0].usec} > {in_r.now_sec, nusec};
    borrow = ent[0].usec < nusec;
    hu_ext = borrow ? (21'(ent[0].usec) + 21'(teq_pkg::USEC_PER_SEC))
                    : 21'(ent[0].usec);
  end

  always_comb begin
    out_nxt = '0;
    case (in_r.cmd)
      teq_pkg::CMD_ADD: begin
        out_nxt.status = full ? teq_pkg::ST_FULL : teq_pkg::ST_OK;
      end
      teq_pkg::CMD_POP: begin
        if (empty) begin
          out_nxt.status = teq_pkg::ST_MISS;
        end else begin
          out_nxt.out_handle  = ent[0].handle;
          out_nxt.out_payload = ent[0].payload;
        end
      end
      teq_pkg::CMD_REMOVE: begin
        out_nxt.status = found ? teq_pkg::ST_OK : teq_pkg::ST_MISS;
      end
      teq_pkg::CMD_QUERY: begin
        if (empty) begin
          out_nxt.status   = teq_pkg::ST_MISS;
          out_nxt.wait_sec = idle_wait_r;
        end else begin
          out_nxt.head_due = !later;
          if (later) begin
            out_nxt.wait_usec = 20'(hu_ext - 21'(nusec));
            out_nxt.wait_sec  = ent[0].sec - in_r.now_sec - 32'(borrow);
          end
        end
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef SYNTHESIS
  // occupied slots are contiguous from the head
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_vec + D'(1)) & vld_vec) == '0)
    else $error("queue slots not contiguous");

  // an add into a non-full queue grows it by exactly one
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (in_r.cmd == teq_pkg::CMD_ADD) && !full) |=>
      ($countones(vld_vec) == $past($countones(vld_vec)) + 1))
    else $error("add did not grow queue by one");

  // a successful remove shrinks it by exactly one
  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (in_r.cmd == teq_pkg::CMD_REMOVE) && found) |=>
      ($countones(vld_vec) + 1 == $past($countones(vld_vec))))
    else $error("remove did not shrink queue by one");

  // due flag only on a good query result
  a_due_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.head_due && (out_r.status != teq_pkg::ST_OK)))
    else $error("head_due with bad status");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// testbench for the timer event queue: random and directed commands checked against a predictor
`default_nettype none

module tb;
  import teq_pkg::*;

  // idle cycles with no handshake or config write before the run is declared hung
  localparam int unsigned STALL_LIMIT  = 2000;
  // cycles the block may still be busy after its last result
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 275;
  localparam int unsigned BLOCK_ITEMS  = 30;

  // random command mixes
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_wr_en;
  logic [31:0] cfg_wr_data;

  timer_event_queue uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock: period 4
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // predicted queue contents, kept in deadline order with slot 0 as head
  // ---------------------------------------------------------------------
  logic [31:0] slot_sec     [QUEUE_DEPTH];
  logic [19:0] slot_usec    [QUEUE_DEPTH];
  logic [31:0] slot_handle  [QUEUE_DEPTH];
  logic [31:0] slot_payload [QUEUE_DEPTH];
  int unsigned slot_count;
  logic [31:0] idle_wait;

  // word streams
  in_word_t  cmd_backlog[$];        // words waiting to be driven
  out_word_t predicted_replies[$];  // results owed by the block, oldest first

  int unsigned errors;
  int unsigned words_sent, replies_seen;
  int unsigned cmd_seen [4];
  int unsigned full_hits, miss_hits, due_hits, peak_count;

  // close the gap left by a removed slot
  function automatic void drop_slot(int unsigned pos);
    for (int unsigned i = pos; i + 1 < slot_count; i++) begin
      slot_sec[i]     = slot_sec[i + 1];
      slot_usec[i]    = slot_usec[i + 1];
      slot_handle[i]  = slot_handle[i + 1];
      slot_payload[i] = slot_payload[i + 1];
    end
    slot_count--;
  endfunction

  // apply one command word to the predicted queue and return its result word
  function automatic out_word_t timer_apply(in_word_t w);
    out_word_t   r;
    logic [19:0] nu;
    logic [63:0] tu, ts;
    logic [31:0] ds, hs, hu;
    logic [19:0] du;
    int unsigned pos;
    bit          found;
    r  = '0;
    // out-of-range microseconds of now are clamped
    nu = (w.now_usec > USEC_MAX) ? USEC_MAX : w.now_usec;
    cmd_seen[w.cmd]++;
    case (w.cmd)
      CMD_ADD: begin
        if (slot_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tu = 64'(nu) + 64'(w.delay_ms) * 64'(USEC_PER_MS);
          ts = 64'(w.now_sec);
          // carry whole seconds out of the microsecond sum
          if (tu >= 64'(USEC_PER_SEC)) begin
            ts = ts + tu / 64'(USEC_PER_SEC);
            tu = tu % 64'(USEC_PER_SEC);
          end
          // seconds past the top saturate to the last representable instant
          if (ts > 64'hFFFF_FFFF) begin
            ds = 32'hFFFF_FFFF;
            du = USEC_MAX;
          end else begin
            ds = ts[31:0];
            du = tu[19:0];
          end
          // new event goes ahead of any with an equal deadline
          pos = 0;
          while (pos < slot_count && {ds, du} > {slot_sec[pos], slot_usec[pos]}) pos++;
          for (int unsigned i = slot_count; i > pos; i--) begin
            slot_sec[i]     = slot_sec[i - 1];
            slot_usec[i]    = slot_usec[i - 1];
            slot_handle[i]  = slot_handle[i - 1];
            slot_payload[i] = slot_payload[i - 1];
          end
          slot_sec[pos]     = ds;
          slot_usec[pos]    = du;
          slot_handle[pos]  = w.event_handle;
          slot_payload[pos] = w.event_payload;
          slot_count++;
          if (slot_count > peak_count) peak_count = slot_count;
        end
      end
      CMD_POP: begin
        if (slot_count == 0) begin
          r.status = ST_MISS;
        end else begin
          r.out_handle  = slot_handle[0];
          r.out_payload = slot_payload[0];
          drop_slot(0);
        end
      end
      CMD_REMOVE: begin
        // first match counted from the head
        found = 1'b0;
        for (int unsigned i = 0; i < slot_count; i++) begin
          if (slot_handle[i] == w.event_handle) begin
            drop_slot(i);
            found = 1'b1;
            break;
          end
        end
        r.status = found ? ST_OK : ST_MISS;
      end
      default: begin
        if (slot_count == 0) begin
          r.status   = ST_MISS;
          r.wait_sec = idle_wait;
        end else if ({slot_sec[0], slot_usec[0]} <= {w.now_sec, nu}) begin
          // deadline reached: no wait left
          r.head_due = 1'b1;
        end else begin
          hs = slot_sec[0];
          hu = 32'(slot_usec[0]);
          // borrow a second when the microseconds fall short
          if (hu < 32'(nu)) begin
            hu = hu + 32'(USEC_PER_SEC);
            hs = hs - 1;
          end
          r.wait_usec = 20'(hu - 32'(nu));
          r.wait_sec  = hs - w.now_sec;
        end
      end
    endcase
    if (r.status == ST_FULL) full_hits++;
    if (r.status == ST_MISS) miss_hits++;
    if (r.head_due) due_hits++;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // ---------------------------------------------------------------------
  // input side driver: one word per handshake, random gap after each word
  // ---------------------------------------------------------------------
  logic        in_fire, out_fire;
  int unsigned in_gap, out_hold, next_hold;
  bit          quiet_in, quiet_out;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (cmd_backlog.size() != 0) begin
        in_word  <= cmd_backlog.pop_front();
        in_valid <= 1'b1;
        in_gap   <= quiet_in ? 0 : $urandom_range(0, 18);
        // now and then switch between gappy and back-to-back stretches
        if ($urandom_range(0, 59) == 0) quiet_in <= !quiet_in;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: random stall drawn after every accepted result
  always @(negedge clk) begin
    if (rst_n) begin
      next_hold = out_hold;
      if (out_fire) begin
        next_hold = quiet_out ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 59) == 0) quiet_out = !quiet_out;
      end
      out_stall <= (next_hold != 0);
      out_hold = (next_hold != 0) ? next_hold - 1 : 0;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: predict on intake, check on delivery, track config writes
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      slot_count = 0;
      idle_wait  = 32'hFFFF_FFFF;
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;
      if (cfg_wr_en) idle_wait = cfg_wr_data;
      // check first so a result never pairs with a word taken this same edge
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (predicted_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_word);
        end else begin
          out_word_t exp_w;
          exp_w = predicted_replies.pop_front();
          check_field("status",      32'(exp_w.status),    32'(out_word.status));
          check_field("out_handle",  exp_w.out_handle,     out_word.out_handle);
          check_field("out_payload", exp_w.out_payload,    out_word.out_payload);
          check_field("wait_sec",    exp_w.wait_sec,       out_word.wait_sec);
          check_field("wait_usec",   32'(exp_w.wait_usec), 32'(out_word.wait_usec));
          check_field("head_due",    32'(exp_w.head_due),  32'(out_word.head_due));
        end
      end
      if (in_valid && !in_stall) begin
        words_sent++;
        predicted_replies.push_back(timer_apply(in_word));
      end
    end
  end

  // watchdog: cycles without any handshake or config write
  int unsigned hung_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      hung_cycles <= 0;
    end else if (hung_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, predicted_replies.size());
      $display("timer_event_queue test failed");
      $finish;
    end else begin
      hung_cycles <= hung_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  logic [31:0] gen_sec;
  logic [19:0] gen_usec;

  function automatic in_word_t make_cmd(logic [1:0] c, logic [31:0] h, logic [31:0] p,
                                        logic [21:0] d, logic [31:0] s, logic [19:0] u);
    in_word_t w;
    w.cmd           = c;
    w.event_handle  = h;
    w.event_payload = p;
    w.delay_ms      = d;
    w.now_sec       = s;
    w.now_usec      = u;
    return w;
  endfunction

  // random command around a slowly advancing clock, weighted by mode
  function automatic in_word_t random_command(int mode);
    in_word_t    w;
    int unsigned r, add_w, pop_w, rem_w;
    case (mode)
      MODE_FILL:  begin add_w = 70; pop_w = 10; rem_w = 10; end
      MODE_DRAIN: begin add_w = 15; pop_w = 45; rem_w = 25; end
      default:    begin add_w = 35; pop_w = 20; rem_w = 20; end
    endcase
    r = $urandom_range(0, 99);
    if (r < add_w)                      w.cmd = CMD_ADD;
    else if (r < add_w + pop_w)         w.cmd = CMD_POP;
    else if (r < add_w + pop_w + rem_w) w.cmd = CMD_REMOVE;
    else                                w.cmd = CMD_QUERY;

    // small handle pool so removes find their targets and duplicates occur
    r = $urandom_range(0, 99);
    if (r < 75)      w.event_handle = $urandom_range(1, 24);
    else if (r < 85) w.event_handle = '0;
    else             w.event_handle = $urandom;
    w.event_payload = $urandom;

    r = $urandom_range(0, 99);
    if (r < 60)      w.delay_ms = 22'($urandom_range(0, 2000));
    else if (r < 75) w.delay_ms = '0;
    else if (r < 85) w.delay_ms = 22'($urandom_range(0, 2147483));
    else if (r < 95) w.delay_ms = 22'($urandom);
    else             w.delay_ms = '1;

    // advance the clock; rare jumps, some close to the seconds limit
    gen_usec = gen_usec + 20'($urandom_range(0, 400000));
    if (gen_usec >= USEC_PER_SEC) begin
      gen_usec = gen_usec - USEC_PER_SEC;
      gen_sec  = gen_sec + 1;
    end
    r = $urandom_range(0, 99);
    if (r < 2)      gen_sec = $urandom;
    else if (r < 4) gen_sec = 32'hFFFF_FFFF - $urandom_range(0, 5);
    w.now_sec = gen_sec;

    r = $urandom_range(0, 99);
    if (r < 90)      w.now_usec = gen_usec;
    else if (r < 95) w.now_usec = 20'($urandom);
    else             w.now_usec = USEC_MAX;
    return w;
  endfunction

  // wait until every word is taken and answered, then let the block settle
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || predicted_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_idle_wait(logic [31:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [31:0] phase_cfg [6];
    int          mode;
    errors      = 0;
    words_sent  = 0;
    replies_seen = 0;
    full_hits   = 0;
    miss_hits   = 0;
    due_hits    = 0;
    peak_count  = 0;
    cmd_seen    = '{default: 0};
    in_gap      = 0;
    out_hold    = 0;
    hung_cycles = 0;
    gen_sec     = 32'd1000;
    gen_usec    = '0;
    in_valid    = 1'b0;
    in_word     = '0;
    out_stall   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    rst_n       = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty queue cases under the reset idle wait
    cmd_backlog.push_back(make_cmd(CMD_QUERY,  0, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_POP,    0, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 5, 0, 0, 0, 0));
    // equal deadlines: the later add must come out first
    cmd_backlog.push_back(make_cmd(CMD_ADD, 1, 32'h11, 0, 100, 0));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 2, 32'h22, 0, 100, 0));
    // microsecond sum of exactly one million, and just above
    cmd_backlog.push_back(make_cmd(CMD_ADD, 3, 32'h33, 1, 100, 20'd999000));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 4, 32'h44, 1, 100, USEC_MAX));
    // microseconds beyond range get clamped
    cmd_backlog.push_back(make_cmd(CMD_ADD, 5, 32'h55, 0, 100, 20'hFFFFF));
    // seconds overflow saturates; big delay near the top without overflow
    cmd_backlog.push_back(make_cmd(CMD_ADD, 6, 32'h66, 22'h3FFFFF, 32'hFFFF_FFFF, USEC_MAX));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 7, 32'h77, 22'd2147483, 32'hFFFF_F000, 0));
    // all-ones and all-zeros handle and payload
    cmd_backlog.push_back(make_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 0, 22'd999, 50, 20'd500000));
    // fill to the top, then one add too many
    for (int k = 0; k < 7; k++)
      cmd_backlog.push_back(make_cmd(CMD_ADD, 8 + k, $urandom, 22'(10 * k), 200, 0));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 99, 32'h99, 0, 0, 0));
    // head due exactly now, pop it, then a wait that needs a borrow
    cmd_backlog.push_back(make_cmd(CMD_QUERY,  0, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_POP,    0, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_QUERY,  0, 0, 0, 49, 20'd800000));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 3, 0, 0, 0, 0));
    // deadline long passed, clamped now
    cmd_backlog.push_back(make_cmd(CMD_QUERY,  0, 0, 0, 32'hFFFF_FFFF, 20'hFFFFF));
    wait_drained();

    // random phases, each under its own idle wait setting
    phase_cfg[0] = 32'h0;
    phase_cfg[1] = 32'hFFFF_FFFF;
    phase_cfg[2] = $urandom;
    phase_cfg[3] = 32'h1;
    phase_cfg[4] = 32'h8000_0000;
    phase_cfg[5] = $urandom;
    foreach (phase_cfg[ph]) begin
      write_idle_wait(phase_cfg[ph]);
      mode = MODE_MIX;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % BLOCK_ITEMS == 0) mode = $urandom_range(MODE_FILL, MODE_MIX);
        cmd_backlog.push_back(random_command(mode));
      end
      wait_drained();
    end

    if (predicted_replies.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, predicted_replies.size());
    end
    $display("covered %0d words: %0d add, %0d pop, %0d remove, %0d query; peak depth %0d",
             words_sent, cmd_seen[CMD_ADD], cmd_seen[CMD_POP], cmd_seen[CMD_REMOVE],
             cmd_seen[CMD_QUERY], peak_count);
    $display("%0d results checked: %0d full, %0d empty or missing, %0d due; %0d errors",
             replies_seen, full_hits, miss_hits, due_hits, errors);
    if (errors == 0) begin
      $display("timer_event_queue test passed");
    end else begin
      $display("timer_event_queue test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
